>>> rtl/stt_pkg.sv
// Shared types, codes and constants for the search transposition table.
package stt_pkg;

  localparam int INDEX_BITS_DEFAULT = 16;
  localparam int HASH_W  = 64;
  localparam int TAG_W   = 16;
  localparam int TAG_LSB = HASH_W - TAG_W;
  localparam int MOVE_W  = 16;
  localparam int SCORE_W = 16;
  localparam int DEPTH_W = 7;
  localparam int PLY_W   = 7;

  typedef enum logic {
    REQ_PROBE = 1'b0,
    REQ_WRITE = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    FLAG_EXACT = 2'd0,
    FLAG_LOWER = 2'd1,
    FLAG_UPPER = 2'd2,
    FLAG_EMPTY = 2'd3
  } flag_t;

  typedef enum logic {
    CLR_SWEEP = 1'b0,
    CLR_DONE  = 1'b1
  } clr_state_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [MOVE_W-1:0]  mv;
    logic [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0] depth;
    flag_t              flag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t ENTRY_RESET = '{
    tag:   '0,
    mv:    '0,
    score: '0,
    depth: '0,
    flag:  FLAG_EMPTY
  };

  typedef struct packed {
    req_kind_t          kind;
    logic [TAG_W-1:0]   tag;
    logic [MOVE_W-1:0]  move;
    logic [DEPTH_W-1:0] depth;
    logic [SCORE_W-1:0] score;
    flag_t              bound;
    logic [SCORE_W-1:0] alpha;
    logic [SCORE_W-1:0] beta;
    logic [PLY_W-1:0]   ply;
  } req_t;

  typedef struct packed {
    logic               tag_hit;
    logic [MOVE_W-1:0]  stored_move;
    logic               cutoff_valid;
    logic [SCORE_W-1:0] cutoff_value;
    logic               entry_replaced;
  } res_t;

  typedef struct packed {
    logic busy;
    logic we;
  } clr_t;

endpackage

>>> rtl/stt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/stt_clear.sv
// Post-reset sweep that writes the empty entry into every table slot.
module stt_clear #(
  parameter int INDEX_BITS = stt_pkg::INDEX_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  output stt_pkg::clr_t         clr,
  output logic [INDEX_BITS-1:0] addr
);

  stt_pkg::clr_state_t state, state_next;
  logic [INDEX_BITS-1:0] cnt, cnt_next;
  logic last;

  assign last = (cnt == {INDEX_BITS{1'b1}});
  assign addr = cnt;

  always_comb begin
    state_next = state;
    unique case (state)
      stt_pkg::CLR_SWEEP: if (last) state_next = stt_pkg::CLR_DONE;
      stt_pkg::CLR_DONE:  state_next = stt_pkg::CLR_DONE;
      default:            state_next = stt_pkg::CLR_SWEEP;
    endcase
  end

  always_comb begin
    clr      = '0;
    cnt_next = cnt;
    unique case (state)
      stt_pkg::CLR_SWEEP: begin
        clr.busy = 1'b1;
        clr.we   = 1'b1;
        cnt_next = cnt + 1'b1;
      end
      stt_pkg::CLR_DONE: begin
        clr = '0;
      end
      default: begin
        clr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stt_pkg::CLR_SWEEP;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

>>> rtl/stt_resolve.sv
// Probe/cutoff decision and depth-preferred replacement for one slot.
module stt_resolve (
  input  stt_pkg::entry_t entry,
  input  stt_pkg::req_t   req,
  output stt_pkg::res_t   res,
  output stt_pkg::entry_t wr_entry,
  output logic            wr_en
);

  logic replace;
  logic hit;
  logic deep;
  logic signed [stt_pkg::SCORE_W-1:0] sc, alpha, beta;

  assign sc    = $signed(entry.score);
  assign alpha = $signed(req.alpha);
  assign beta  = $signed(req.beta);

  assign replace = (entry.flag == stt_pkg::FLAG_EMPTY) || (entry.depth <= req.depth) ||
                   (entry.flag == stt_pkg::FLAG_EXACT);
  assign hit  = (entry.tag == req.tag);
  assign deep = (entry.depth >= req.depth) && (req.ply != '0);

  assign wr_en    = (req.kind == stt_pkg::REQ_WRITE) && replace;
  assign wr_entry = '{
    tag:   req.tag,
    mv:    req.move,
    score: req.score,
    depth: req.depth,
    flag:  req.bound
  };

  always_comb begin
    res = '0;
    if (req.kind == stt_pkg::REQ_WRITE) begin
      res.entry_replaced = replace;
    end else if (hit) begin
      res.tag_hit     = 1'b1;
      res.stored_move = entry.mv;
      if (deep) begin
        if (entry.flag == stt_pkg::FLAG_EXACT) begin
          res.cutoff_valid = 1'b1;
          res.cutoff_value = entry.score;
        end else if (entry.flag == stt_pkg::FLAG_LOWER && sc >= beta) begin
          res.cutoff_valid = 1'b1;
          res.cutoff_value = req.beta;
        end else if (entry.flag == stt_pkg::FLAG_UPPER && sc <= alpha) begin
          res.cutoff_valid = 1'b1;
          res.cutoff_value = req.alpha;
        end
      end
    end
  end

endmodule

>>> rtl/search_transposition_table.sv
// Top level of the search transposition table: request pipeline around the entry RAM.
// Direct-mapped table of 2^INDEX_BITS entries, indexed by the low hash bits and
// tagged with hash bits 63..48. After reset the block sweeps every slot to the empty
// entry, one slot per cycle, and in_stall stays high for the whole sweep. Afterwards one
// word is taken per cycle while the output is not stalled: the slot is read from the RAM
// on the accept edge, then the resolve stage decides the probe or replacement and, when the
// word advances, writes the slot back and loads the output register. A request that hits
// the slot written on its own accept edge takes the forwarded entry. The single RAM
// sustains one read-modify-write per cycle while the output is not stalled.
module search_transposition_table #(
  parameter int INDEX_BITS = stt_pkg::INDEX_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               req_type,
  input  logic [stt_pkg::HASH_W-1:0]         position_hash,
  input  logic [stt_pkg::MOVE_W-1:0]         entry_move,
  input  logic [stt_pkg::DEPTH_W-1:0]        search_depth,
  input  logic signed [stt_pkg::SCORE_W-1:0] entry_score,
  input  logic [1:0]                         bound_kind,
  input  logic signed [stt_pkg::SCORE_W-1:0] window_low,
  input  logic signed [stt_pkg::SCORE_W-1:0] window_high,
  input  logic [stt_pkg::PLY_W-1:0]          ply_from_root,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               tag_hit,
  output logic [stt_pkg::MOVE_W-1:0]         stored_move,
  output logic                               cutoff_valid,
  output logic signed [stt_pkg::SCORE_W-1:0] cutoff_value,
  output logic                               entry_replaced
);

  localparam int DEPTH = 1 << INDEX_BITS;

  stt_pkg::clr_t         clr;
  logic [INDEX_BITS-1:0] clr_addr;

  logic                  accept, adv;
  logic [INDEX_BITS-1:0] in_index;
  stt_pkg::req_t         in_req;

  logic                  a_valid, a_valid_next;
  logic                  a_fwd, a_fwd_next;
  logic [INDEX_BITS-1:0] a_index;
  stt_pkg::req_t         a_req;
  stt_pkg::entry_t       last_wr;

  logic [stt_pkg::ENTRY_W-1:0] rdata;
  stt_pkg::entry_t       entry;
  stt_pkg::res_t         res;
  stt_pkg::entry_t       wr_entry;
  logic                  wr_en, pipe_we;

  logic                  ram_we;
  logic [INDEX_BITS-1:0] ram_waddr;
  logic [stt_pkg::ENTRY_W-1:0] ram_wdata;

  logic out_valid_next;

  assign in_index = position_hash[INDEX_BITS-1:0];
  assign in_req = '{
    kind:  stt_pkg::req_kind_t'(req_type),
    tag:   position_hash[stt_pkg::HASH_W-1:stt_pkg::TAG_LSB],
    move:  entry_move,
    depth: search_depth,
    score: entry_score,
    bound: stt_pkg::flag_t'(bound_kind),
    alpha: window_low,
    beta:  window_high,
    ply:   ply_from_root
  };

  assign adv      = a_valid && (!out_valid || !out_stall);
  assign in_stall = clr.busy || (a_valid && !adv);
  assign accept   = in_valid && !in_stall;

  assign entry   = a_fwd ? last_wr : stt_pkg::entry_t'(rdata);
  assign pipe_we = adv && wr_en;

  assign ram_we    = clr.we || pipe_we;
  assign ram_waddr = clr.busy ? clr_addr : a_index;
  assign ram_wdata = clr.busy ? stt_pkg::ENTRY_RESET : wr_entry;

  assign a_valid_next   = accept || (a_valid && !adv);
  assign a_fwd_next     = accept ? (pipe_we && (a_index == in_index)) : (a_fwd && !adv);
  assign out_valid_next = adv || (out_valid && out_stall);

  stt_clear #(
    .INDEX_BITS(INDEX_BITS)
  ) u_clear (
    .clk  (clk),
    .rst  (rst),
    .clr  (clr),
    .addr (clr_addr)
  );

  stt_ram #(
    .WIDTH(stt_pkg::ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_index),
    .rdata (rdata)
  );

  stt_resolve u_resolve (
    .entry    (entry),
    .req      (a_req),
    .res      (res),
    .wr_entry (wr_entry),
    .wr_en    (wr_en)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      a_fwd     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_valid   <= a_valid_next;
      a_fwd     <= a_fwd_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_req   <= in_req;
      a_index <= in_index;
    end
    if (pipe_we) begin
      last_wr <= wr_entry;
    end
    if (adv) begin
      tag_hit        <= res.tag_hit;
      stored_move    <= res.stored_move;
      cutoff_valid   <= res.cutoff_valid;
      cutoff_value   <= $signed(res.cutoff_value);
      entry_replaced <= res.entry_replaced;
    end
  end

  a_no_write_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr.busy |-> !pipe_we && !a_valid)
    else $error("pipeline active during clear sweep");

  a_fwd_needs_item: assert property (@(posedge clk) disable iff (rst)
    a_fwd |-> a_valid)
    else $error("forward flag set without a pending word");

  a_result_from_adv: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(adv))
    else $error("result appeared without a resolved word");

  a_hold_request: assert property (@(posedge clk) disable iff (rst)
    a_valid && !adv |=> a_valid && $stable(a_req) && $stable(a_index))
    else $error("held request changed");

endmodule
